### rtl/decimal_ascii_line_emitter_assert.svh
// assertion macros used by the emitter rtl file
`ifndef DECIMAL_ASCII_LINE_EMITTER_ASSERT_SVH
`define DECIMAL_ASCII_LINE_EMITTER_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds whenever out of reset
`define DALE_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define DALE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define DALE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define DALE_ASSERT_ALWAYS(name, clk, rst_n, expr)
`define DALE_ASSERT_SAME(name, clk, rst_n, ante, cons)
`define DALE_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dale_pkg.sv
// ----------------------------------------------------------------------------
// dale_pkg
// Types, widths, position codes and digit constants for the line emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dale_pkg;

    localparam int VALUE_W   = 16;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = 4;
    localparam int POS_W     = 3;
    localparam int PLACE_W   = 17;
    localparam int CFG_IDX_W = 1;

    // position in a run: the five decimal places, then the two line-end bytes
    localparam logic [POS_W-1:0] POS_TEN_THOUSANDS = 3'd0;
    localparam logic [POS_W-1:0] POS_THOUSANDS     = 3'd1;
    localparam logic [POS_W-1:0] POS_HUNDREDS      = 3'd2;
    localparam logic [POS_W-1:0] POS_TENS          = 3'd3;
    localparam logic [POS_W-1:0] POS_ONES          = 3'd4;
    localparam logic [POS_W-1:0] POS_EOL_FIRST     = 3'd5;
    localparam logic [POS_W-1:0] POS_EOL_SECOND    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_SECOND = 1'b1;

    localparam logic [CHAR_W-1:0] ASCII_ZERO          = 8'd48;
    localparam logic [CHAR_W-1:0] LINE_END_FIRST_RST  = 8'd10;
    localparam logic [CHAR_W-1:0] LINE_END_SECOND_RST = 8'd13;

    typedef struct packed {
        logic [CHAR_W-1:0] first;
        logic [CHAR_W-1:0] second;
    } dale_eol_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [VALUE_W-1:0] rem;
    } dale_digit_t;

    // k times the place value of a position; k is a constant at every call site
    function automatic logic [PLACE_W-1:0] place_multiple(
        input logic [POS_W-1:0] pos,
        input int unsigned      k
    );
        logic [PLACE_W-1:0] m;
        begin
            unique case (pos)
                POS_TEN_THOUSANDS: m = PLACE_W'(k * 10000);
                POS_THOUSANDS:     m = PLACE_W'(k * 1000);
                POS_HUNDREDS:      m = PLACE_W'(k * 100);
                POS_TENS:          m = PLACE_W'(k * 10);
                default:           m = PLACE_W'(k);
            endcase
            return m;
        end
    endfunction

    // first printed place: the highest one the value reaches, ones for zero
    function automatic logic [POS_W-1:0] start_pos(input logic [VALUE_W-1:0] v);
        logic [POS_W-1:0] p;
        begin
            priority if (v >= 16'd10000) p = POS_TEN_THOUSANDS;
            else if (v >= 16'd1000)      p = POS_THOUSANDS;
            else if (v >= 16'd100)       p = POS_HUNDREDS;
            else if (v >= 16'd10)        p = POS_TENS;
            else                         p = POS_ONES;
            return p;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/dale_if.sv
// ----------------------------------------------------------------------------
// dale_value_if / dale_char_if
// Valid/ready channels for the input value and the output characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface dale_value_if;
    import dale_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dale_char_if;
    import dale_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### rtl/dale_cfg_regs.sv
// ----------------------------------------------------------------------------
// dale_cfg_regs
// Line-end character registers behind the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dale_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [dale_pkg::CFG_IDX_W-1:0]  index,
    input  logic [dale_pkg::CHAR_W-1:0]     wdata,
    output dale_pkg::dale_eol_t             eol
);
    import dale_pkg::*;

    dale_eol_t eol_reg;
    dale_eol_t eol_next;

    always_comb
    begin
        eol_next = eol_reg;
        if (wr_en)
        begin
            unique case (index)
                CFG_LINE_END_FIRST:  eol_next.first  = wdata;
                CFG_LINE_END_SECOND: eol_next.second = wdata;
                default:             eol_next        = eol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eol_reg.first  <= LINE_END_FIRST_RST;
            eol_reg.second <= LINE_END_SECOND_RST;
        end
        else
        begin
            eol_reg <= eol_next;
        end
    end

    assign eol = eol_reg;

endmodule

`default_nettype wire

### rtl/dale_digit_unit.sv
// ----------------------------------------------------------------------------
// dale_digit_unit
// One decimal digit of the remainder at a given place, by parallel compares.
// ----------------------------------------------------------------------------
`default_nettype none

module dale_digit_unit (
    input  logic [dale_pkg::POS_W-1:0]   pos,
    input  logic [dale_pkg::VALUE_W-1:0] rem,
    output dale_pkg::dale_digit_t        result
);
    import dale_pkg::*;

    logic [DIGIT_W-1:0] digit;
    logic [PLACE_W-1:0] sub;
    logic [PLACE_W-1:0] rem_ext;
    logic [PLACE_W-1:0] diff;

    assign rem_ext = PLACE_W'(rem);

    // compares are monotonic in k, so the highest one passing wins
    always_comb
    begin
        digit = '0;
        sub   = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_ext >= place_multiple(pos, k))
            begin
                digit = DIGIT_W'(k);
                sub   = place_multiple(pos, k);
            end
        end
    end

    assign diff         = rem_ext - sub;
    assign result.digit = digit;
    assign result.rem   = diff[VALUE_W-1:0];

endmodule

`default_nettype wire

### rtl/dale_emitter.sv
// ----------------------------------------------------------------------------
// dale_emitter
// Holds one value, steps through its printed places and the line ends,
// and presents one character per cycle, unless char_ch stalls, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_ascii_line_emitter_assert.svh"

module dale_emitter (
    input  logic                clk,
    input  logic                rst_n,
    dale_value_if.sink          value_ch,
    dale_char_if.source         char_ch,
    input  dale_pkg::dale_eol_t eol
);
    import dale_pkg::*;

    logic               busy_reg;
    logic               busy_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [VALUE_W-1:0] rem_reg;
    logic [VALUE_W-1:0] rem_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg;
    logic [CHAR_W-1:0]  out_char_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic        adv;
    logic        emit;
    logic        final_emit;
    logic        take;
    dale_digit_t dig;

    dale_digit_unit u_digit (
        .pos    (pos_reg),
        .rem    (rem_reg),
        .result (dig)
    );

    // output slot free or being emptied this cycle
    assign adv        = !out_valid_reg || char_ch.ready;
    assign emit       = busy_reg && adv;
    assign final_emit = emit && (pos_reg == POS_EOL_SECOND);

    assign value_ch.ready = !busy_reg || final_emit;
    assign take           = value_ch.valid && value_ch.ready;

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        rem_next  = rem_reg;
        if (emit)
        begin
            if (final_emit)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                rem_next = dig.rem;
            end
        end
        // leading zeros are skipped: below the start place the value is its own remainder
        if (take)
        begin
            busy_next = 1'b1;
            rem_next  = value_ch.value;
            pos_next  = start_pos(value_ch.value);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !char_ch.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            priority if (pos_reg <= POS_ONES)
            begin
                out_char_next = ASCII_ZERO + CHAR_W'(dig.digit);
                out_last_next = 1'b0;
            end
            else if (pos_reg == POS_EOL_FIRST)
            begin
                out_char_next = eol.first;
                out_last_next = 1'b0;
            end
            else
            begin
                out_char_next = eol.second;
                out_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_EOL_SECOND;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign char_ch.valid     = out_valid_reg;
    assign char_ch.character = out_char_reg;
    assign char_ch.last      = out_last_reg;

    `DALE_ASSERT_ALWAYS(a_pos_range, clk, rst_n, !busy_reg || (pos_reg <= POS_EOL_SECOND))
    `DALE_ASSERT_SAME(a_ready_only_at_end, clk, rst_n, busy_reg && value_ch.ready, pos_reg == POS_EOL_SECOND)
    `DALE_ASSERT_SAME(a_ones_rem_small, clk, rst_n, busy_reg && (pos_reg == POS_ONES), rem_reg < 16'd10)
    `DALE_ASSERT_NEXT(a_run_continues, clk, rst_n, emit && !final_emit, busy_reg && out_valid_reg && !out_last_reg)

endmodule

`default_nettype wire

### rtl/decimal_ascii_line_emitter.sv
// ----------------------------------------------------------------------------
// decimal_ascii_line_emitter
// Prints a 16-bit unsigned value as decimal ASCII, most significant digit
// first without leading zeros, followed by two configurable line-end bytes.
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                          item
//   value_ch   in    value[15:0]                      one number
//   char_ch    out   character[7:0], last             one character, last on final
//   cfg port   in    cfg_wr_en/cfg_index/cfg_wdata    one register write
//
// one character leaves per cycle unless char_ch stalls; a value gives 3 to 7
// characters, the rate set by the single place-digit unit in the sequencer
// the next value is taken in the cycle its predecessor's final byte is loaded
// a stall on char_ch holds the output register and freezes the sequencer
// reset empties the sequencer and sets the line ends to 10 and 13
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_ascii_line_emitter (
    input  logic                           clk,
    input  logic                           rst_n,
    dale_value_if.sink                     value_ch,
    dale_char_if.source                    char_ch,
    input  logic                           cfg_wr_en,
    input  logic [dale_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dale_pkg::CHAR_W-1:0]    cfg_wdata
);
    import dale_pkg::*;

    dale_eol_t eol;

    dale_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .wdata (cfg_wdata),
        .eol   (eol)
    );

    dale_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .char_ch  (char_ch),
        .eol      (eol)
    );

endmodule

`default_nettype wire
